### rtl/bms_pkg.sv
// ----------------------------------------------------------------------------
// bms_pkg: shared types and constants for the bitap mismatch search
// Vector geometry, register indexes, configuration bundle and queue entry.
// ----------------------------------------------------------------------------
package bms_pkg;

	localparam int PAT_BYTES  = 31;
	localparam int VEC_BITS   = PAT_BYTES + 1;
	localparam int LEVELS     = 8;
	localparam int LEVEL_BITS = $clog2(LEVELS);
	localparam int LEN_BITS   = $clog2(VEC_BITS);
	localparam int POS_BITS   = 32;
	localparam int START_BITS = 32;
	localparam int CFG_BITS   = 64;
	localparam int IDX_BITS   = 3;
	localparam int OUT_BITS   = 40;

	localparam logic [VEC_BITS-1:0] VEC_RESET = ~VEC_BITS'(1);
	localparam logic [POS_BITS-1:0] POS_MAX   = '1;

	// configuration register indexes
	localparam logic [IDX_BITS-1:0] REG_PATTERN_LENGTH = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] REG_MAX_ERRORS     = IDX_BITS'(1);
	localparam logic [IDX_BITS-1:0] REG_PATTERN_0      = IDX_BITS'(2);
	localparam logic [IDX_BITS-1:0] REG_PATTERN_1      = IDX_BITS'(3);
	localparam logic [IDX_BITS-1:0] REG_PATTERN_2      = IDX_BITS'(4);
	localparam logic [IDX_BITS-1:0] REG_PATTERN_3      = IDX_BITS'(5);

	typedef struct packed {
		logic [PAT_BYTES*8-1:0] pattern;
		logic [LEN_BITS-1:0]    pattern_length;
		logic [LEVEL_BITS-1:0]  max_errors;
	} cfg_t;

	// classified text byte, as queued between front and back
	typedef struct packed {
		logic [VEC_BITS-1:0] mask;
		logic                sot;
		logic                empty_pat;
	} item_t;

endpackage

### rtl/bms_front.sv
// ----------------------------------------------------------------------------
// bms_front: input side of the bitap mismatch search
// Accepts text bytes and classifies each into a character mask for the queue.
// ----------------------------------------------------------------------------
module bms_front (
	input  bms_pkg::cfg_t  cfg,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [7:0]     s_tdata,   // [7:0] text_byte
	input  logic           s_tuser,   // [0] start_of_text
	input  logic           q_full,
	output logic           q_push,
	output bms_pkg::item_t q_item
);
	import bms_pkg::*;

	logic [VEC_BITS-1:0] mask;

	// compare the byte against every pattern byte in use
	always_comb begin
		mask = '1;
		for (int i = 0; i < PAT_BYTES; i++) begin
			if ((LEN_BITS'(i) < cfg.pattern_length) && (cfg.pattern[i*8 +: 8] == s_tdata)) begin
				mask[i] = 1'b0;
			end
		end
	end

	assign s_tready            = ~q_full;
	assign q_push              = s_tvalid & ~q_full;
	assign q_item.mask         = mask;
	assign q_item.sot          = s_tuser;
	assign q_item.empty_pat    = (cfg.pattern_length == '0);

endmodule

### rtl/bms_queue.sv
// ----------------------------------------------------------------------------
// bms_queue: short queue between front and back
// Four-entry register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module bms_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bms_pkg::item_t push_item,
	input  logic           pop,
	output bms_pkg::item_t head_item,
	output logic           not_empty,
	output logic           full
);
	import bms_pkg::*;

	localparam int DEPTH     = 4;
	localparam int PTR_BITS  = $clog2(DEPTH);
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	item_t               entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_BITS'(DEPTH));
	assign head_item = entry_q[rd_ptr_q];

	// store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

endmodule

### rtl/bms_back.sv
// ----------------------------------------------------------------------------
// bms_back: search engine of the bitap mismatch search
// Updates all error-level vectors, position and found flag; registers results.
// ----------------------------------------------------------------------------
module bms_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bms_pkg::cfg_t            cfg,
	input  logic                     q_not_empty,
	input  bms_pkg::item_t           q_item,
	output logic                     q_pop,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [bms_pkg::OUT_BITS-1:0] m_tdata  // [0] match_found, [32:1] match_start,
	                                            // [33] search_finished, [39:34] zero
);
	import bms_pkg::*;

	logic [VEC_BITS-1:0]   vec_q [LEVELS];
	logic [POS_BITS-1:0]   pos_q;
	logic                  found_q;
	logic                  out_valid_q;
	logic                  out_found_q;
	logic [START_BITS-1:0] out_start_q;
	logic                  out_finished_q;

	logic [VEC_BITS-1:0]   base_vec [LEVELS];
	logic [VEC_BITS-1:0]   upd_vec  [LEVELS];
	logic [VEC_BITS-1:0]   next_vec [LEVELS];
	logic [POS_BITS-1:0]   base_pos;
	logic [POS_BITS-1:0]   next_pos;
	logic                  base_found;
	logic                  next_found;
	logic                  hit;
	logic                  vec_hit;
	logic [POS_BITS:0]     pos_plus;
	logic [POS_BITS:0]     len_ext;
	logic [POS_BITS:0]     diff;
	logic [START_BITS-1:0] start;

	assign q_pop = q_not_empty & (~out_valid_q | m_tready);

	// start of text clears the search state ahead of this byte
	always_comb begin
		for (int d = 0; d < LEVELS; d++) begin
			base_vec[d] = q_item.sot ? VEC_RESET : vec_q[d];
		end
		base_pos   = q_item.sot ? '0 : pos_q;
		base_found = q_item.sot ? 1'b0 : found_q;
	end

	// update every error level in parallel from the old vectors
	always_comb begin
		upd_vec[0] = (base_vec[0] | q_item.mask) << 1;
		for (int d = 1; d < LEVELS; d++) begin
			upd_vec[d] = (base_vec[d-1] & (base_vec[d] | q_item.mask)) << 1;
		end
	end

	assign vec_hit  = ~upd_vec[cfg.max_errors][cfg.pattern_length];
	assign pos_plus = {1'b0, base_pos} + (POS_BITS+1)'(1);
	assign len_ext  = (POS_BITS+1)'(cfg.pattern_length);
	assign diff     = pos_plus - len_ext;

	// decide hit, start and next state
	always_comb begin
		hit        = 1'b0;
		start      = '0;
		next_pos   = base_pos;
		next_found = base_found;
		for (int d = 0; d < LEVELS; d++) begin
			next_vec[d] = base_vec[d];
		end
		if (!base_found) begin
			if (q_item.empty_pat) begin
				hit = 1'b1;
			end else begin
				for (int d = 0; d < LEVELS; d++) begin
					next_vec[d] = upd_vec[d];
				end
				hit = vec_hit;
				if (vec_hit && (pos_plus >= len_ext)) begin
					start = diff[START_BITS-1:0];
				end
			end
			if (base_pos != POS_MAX) begin
				next_pos = pos_plus[POS_BITS-1:0];
			end
			next_found = hit;
		end
	end

	// hold search state, advance on each popped byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < LEVELS; d++) begin
				vec_q[d] <= VEC_RESET;
			end
			pos_q   <= '0;
			found_q <= 1'b0;
		end else if (q_pop) begin
			for (int d = 0; d < LEVELS; d++) begin
				vec_q[d] <= next_vec[d];
			end
			pos_q   <= next_pos;
			found_q <= next_found;
		end
	end

	// output register: load on pop, drop after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_found_q    <= hit;
			out_start_q    <= start;
			out_finished_q <= next_found;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_BITS-START_BITS-2)'(0), out_finished_q, out_start_q, out_found_q};

endmodule

### rtl/bitap_mismatch_search.sv
// ----------------------------------------------------------------------------
// bitap_mismatch_search: shift-or text search with up to k substitutions
// Front classifies each text byte into a character mask, a four-entry queue
// decouples it from the back, which updates the vectors and reports matches.
// ----------------------------------------------------------------------------
// A byte's result is valid on m_tvalid once the byte has passed the queue and
// then the output register.
// Throughput: one byte per cycle while m_tready keeps the output register free;
// in the back end all eight error levels update together.
// Reset: arst_n clears configuration, vectors, position, found flag, queue
// pointers and count, and output valid flag; no clearing pass is needed.
module bitap_mismatch_search (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bms_pkg::IDX_BITS-1:0] cfg_index,
	input  logic [bms_pkg::CFG_BITS-1:0] cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] text_byte
	input  logic                         s_tuser,   // [0] start_of_text
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [bms_pkg::OUT_BITS-1:0] m_tdata    // [0] match_found, [32:1] match_start,
	                                                // [33] search_finished, [39:34] zero
);
	import bms_pkg::*;

	cfg_t  cfg_q;
	item_t push_item;
	item_t head_item;
	logic  q_push;
	logic  q_pop;
	logic  q_full;
	logic  q_not_empty;

	// configuration writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_data[LEN_BITS-1:0];
				REG_MAX_ERRORS:     cfg_q.max_errors     <= cfg_data[LEVEL_BITS-1:0];
				REG_PATTERN_0:      cfg_q.pattern[63:0]    <= cfg_data;
				REG_PATTERN_1:      cfg_q.pattern[127:64]  <= cfg_data;
				REG_PATTERN_2:      cfg_q.pattern[191:128] <= cfg_data;
				REG_PATTERN_3:      cfg_q.pattern[247:192] <= cfg_data[55:0];
				default: begin
				end
			endcase
		end
	end

	bms_front u_front (
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	bms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head_item (head_item),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	bms_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_item      (head_item),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

### sim/bitap_mismatch_search_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitap_mismatch_search_test: self-checking bench for the k-mismatch search
// Streams text bytes through the block under a series of pattern settings,
// tracks the match vectors, position and found flag in a local model and
// compares every result transfer against the oldest predicted result.
// ----------------------------------------------------------------------------
module bitap_mismatch_search_test;

	import bms_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int TARGET_BYTES = 1775;
	localparam int HOLD_AFTER   = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int LOG_CAP      = 200;

	// indexes outside the register map, writes must be dropped
	localparam logic [IDX_BITS-1:0] REG_SPARE_6 = IDX_BITS'(6);
	localparam logic [IDX_BITS-1:0] REG_SPARE_7 = IDX_BITS'(7);

	typedef struct {
		logic                  found;
		logic [START_BITS-1:0] start;
		logic                  finished;
	} match_result_t;

	// Tracks the search state and holds the results still owed by the block
	class match_tracker;
		logic [LEN_BITS-1:0]    pat_len;
		logic [LEVEL_BITS-1:0]  err_lim;
		logic [PAT_BYTES*8-1:0] pattern;
		logic [VEC_BITS-1:0]    vectors [LEVELS];
		logic [POS_BITS-1:0]    position;
		logic                   found;
		match_result_t          owed_results [$];
		int                     error_count;

		function new();
			pat_len     = '0;
			err_lim     = '0;
			pattern     = '0;
			error_count = 0;
			reset_text();
		endfunction

		function void reset_text();
			int d;
			for (d = 0; d < LEVELS; d++)
				vectors[d] = VEC_RESET;
			position = '0;
			found    = 1'b0;
		endfunction

		function void write_register(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
			case (idx)
				REG_PATTERN_LENGTH: pat_len         = data[LEN_BITS-1:0];
				REG_MAX_ERRORS:     err_lim         = data[LEVEL_BITS-1:0];
				REG_PATTERN_0:      pattern[63:0]   = data;
				REG_PATTERN_1:      pattern[127:64] = data;
				REG_PATTERN_2:      pattern[191:128] = data;
				REG_PATTERN_3:      pattern[247:192] = data[55:0];
				default: ;
			endcase
		endfunction

		// Advance the search by one accepted text byte and owe its result
		function void take_byte(logic [7:0] text_byte, logic sot);
			logic [VEC_BITS-1:0]   char_mask;
			logic [VEC_BITS-1:0]   prev_old;
			logic [VEC_BITS-1:0]   cur_old;
			logic [POS_BITS:0]     end_pos;
			logic [START_BITS-1:0] start;
			logic                  hit;
			int                    i;
			int                    d;
			if (sot)
				reset_text();
			hit   = 1'b0;
			start = '0;
			if (!found) begin
				if (pat_len == 0) begin
					hit = 1'b1;
				end else begin
					char_mask = '1;
					for (i = 0; i < pat_len; i++)
						if (pattern[i*8 +: 8] == text_byte)
							char_mask[i] = 1'b0;
					// all levels update from the old vectors
					prev_old   = vectors[0];
					vectors[0] = (vectors[0] | char_mask) << 1;
					for (d = 1; d < LEVELS; d++) begin
						cur_old    = vectors[d];
						vectors[d] = (prev_old & (cur_old | char_mask)) << 1;
						prev_old   = cur_old;
					end
					if (!vectors[err_lim][pat_len]) begin
						hit     = 1'b1;
						end_pos = {1'b0, position} + 1'b1;
						start   = (end_pos >= pat_len) ? START_BITS'(end_pos - pat_len) : '0;
					end
				end
				// saturate the position
				if (position != POS_MAX)
					position = position + 1'b1;
				found = hit;
			end
			owed_results.push_back('{hit, start, found});
		endfunction

		function void report(string field, logic [START_BITS-1:0] want,
				logic [START_BITS-1:0] got);
			if (error_count < LOG_CAP)
				$error("%s mismatch: expected %0h, actual %0h", field, want, got);
			error_count++;
		endfunction

		// Compare one result transfer with the oldest owed result
		function void check_match(logic [OUT_BITS-1:0] data);
			match_result_t want;
			if (owed_results.size() == 0) begin
				if (error_count < LOG_CAP)
					$error("result transfer with nothing owed: %h", data);
				error_count++;
				return;
			end
			want = owed_results.pop_front();
			if (data[0] !== want.found)
				report("match_found", START_BITS'(want.found), START_BITS'(data[0]));
			if (data[32:1] !== want.start)
				report("match_start", want.start, data[32:1]);
			if (data[33] !== want.finished)
				report("search_finished", START_BITS'(want.finished),
				       START_BITS'(data[33]));
		endfunction

		function int outstanding();
			return owed_results.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;   // [7:0] text_byte
	logic                s_tuser;   // [0] start_of_text
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_BITS-1:0] m_tdata;   // [0] match_found, [32:1] match_start,
	                                // [33] search_finished, [39:34] zero

	match_tracker tracker = new();
	int           bytes_in    = 0;
	int           burst_left  = 0;
	int           cycle_count = 0;

	bitap_mismatch_search u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watch both streams at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				tracker.check_match(m_tdata);
			if (s_tvalid && s_tready) begin
				tracker.take_byte(s_tdata, s_tuser);
				bytes_in++;
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Stall the result side on its own pattern, with one long hold-off
	initial begin : receiver
		int  run;
		int  mode;
		bit  held;
		held     = 1'b0;
		m_tready = 1'b0;
		forever begin
			if (!held && bytes_in >= HOLD_AFTER && s_tvalid) begin
				held = 1'b1;
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				run  = $urandom_range(1, 40);
				mode = $urandom_range(0, 3);
				repeat (run) begin
					@(negedge clk);
					case (mode)
						0:       m_tready <= 1'b1;
						1:       m_tready <= 1'($urandom_range(0, 1));
						2:       m_tready <= ($urandom_range(0, 3) != 0);
						default: m_tready <= ($urandom_range(0, 7) == 0);
					endcase
				end
			end
		end
	end

	// Offer one text byte and hold it until transfer; called at a falling edge
	task automatic send_text_byte(input logic [7:0] text_byte, input logic sot);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 24);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= text_byte;
		s_tuser  <= sot;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		tracker.write_register(idx, data);
		@(negedge clk);
	endtask

	// Write every register, with junk in the unused upper bits
	task automatic load_setting(input int m, input int k, input logic [PAT_BYTES*8-1:0] pat);
		logic [CFG_BITS-1:0] data;
		data = {32'($urandom), 32'($urandom)};
		data[LEN_BITS-1:0] = LEN_BITS'(m);
		write_reg(REG_PATTERN_LENGTH, data);
		data = {32'($urandom), 32'($urandom)};
		data[LEVEL_BITS-1:0] = LEVEL_BITS'(k);
		write_reg(REG_MAX_ERRORS, data);
		write_reg(REG_PATTERN_0, pat[63:0]);
		write_reg(REG_PATTERN_1, pat[127:64]);
		write_reg(REG_PATTERN_2, pat[191:128]);
		write_reg(REG_PATTERN_3, {8'($urandom), pat[247:192]});
		write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
		          {32'($urandom), 32'($urandom)});
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Drop valid and wait for every owed result plus the output latency
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	function automatic logic [7:0] filler_byte(input int m, input logic [PAT_BYTES*8-1:0] pat);
		int idx;
		if (m > 0 && $urandom_range(0, 1) != 0) begin
			idx = $urandom_range(0, m - 1);
			return pat[idx*8 +: 8];
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// One text: mostly a pattern window with a few substitutions between
	// filler, else noise, a restart inside the window, or a text continued
	task automatic send_random_text(input int m, input int k, input logic [PAT_BYTES*8-1:0] pat);
		logic [7:0] window [PAT_BYTES];
		int kind;
		int lead;
		int tail;
		int subs;
		int cut;
		int n;
		int i;
		kind = $urandom_range(0, 9);
		if (kind == 7) begin
			n = $urandom_range(1, 40);
			for (i = 0; i < n; i++)
				send_text_byte(8'($urandom_range(0, 255)),
				               (i == 0) || ($urandom_range(0, 7) == 0));
			return;
		end
		for (i = 0; i < m; i++)
			window[i] = pat[i*8 +: 8];
		subs = $urandom_range(0, k + 1);
		for (i = 0; i < subs && m > 0; i++) begin
			n = $urandom_range(0, m - 1);
			window[n] = window[n] ^ 8'($urandom_range(1, 255));
		end
		lead = $urandom_range(0, 12);
		tail = $urandom_range(0, 12);
		cut  = (kind == 8 && m > 1) ? $urandom_range(1, m - 1) : m;
		for (i = 0; i < lead; i++)
			send_text_byte(filler_byte(m, pat), (i == 0) && (kind != 9));
		for (i = 0; i < m; i++)
			send_text_byte(window[i],
			               ((lead == 0) && (i == 0) && (kind != 9)) || (i == cut));
		for (i = 0; i < tail; i++)
			send_text_byte(filler_byte(m, pat), 1'b0);
	endtask

	// Pick a setting, stream texts under it, then drain
	task automatic run_random_phase(input int p);
		logic [PAT_BYTES*8-1:0] pat;
		logic [7:0]             letters [4];
		bit                     narrow;
		int                     m;
		int                     k;
		int                     i;
		int                     phase_start;
		narrow = ($urandom_range(0, 1) != 0);
		for (i = 0; i < 4; i++)
			letters[i] = 8'($urandom_range(0, 255));
		for (i = 0; i < PAT_BYTES; i++)
			pat[i*8 +: 8] = narrow ? letters[$urandom_range(0, 3)]
			                       : 8'($urandom_range(0, 255));
		case (p % 6)
			0:       m = PAT_BYTES;
			1:       m = 1;
			2:       m = (p % 12 == 2) ? 0 : $urandom_range(2, PAT_BYTES);
			default: m = $urandom_range(2, 12);
		endcase
		case (p % 4)
			0:       k = 0;
			1:       k = LEVELS - 1;
			default: k = $urandom_range(0, LEVELS - 1);
		endcase
		load_setting(m, k, pat);
		phase_start = bytes_in;
		while (bytes_in - phase_start < 120)
			send_random_text(m, k, pat);
		drain();
	endtask

	initial begin : stimulus
		logic [PAT_BYTES*8-1:0] pat;
		int                     p;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty pattern out of reset: match at zero, then nothing until restart
		send_text_byte(8'h00, 1'b0);
		send_text_byte(8'hFF, 1'b0);
		send_text_byte(8'h80, 1'b1);
		drain();

		// exact match inside text, byte after the match, near miss
		pat = '0;
		pat[23:0] = "cba";
		load_setting(3, 0, pat);
		send_text_byte("x", 1'b1);
		send_text_byte("a", 1'b0);
		send_text_byte("b", 1'b0);
		send_text_byte("c", 1'b0);
		send_text_byte("d", 1'b0);
		send_text_byte("a", 1'b1);
		send_text_byte("b", 1'b0);
		send_text_byte("d", 1'b0);
		drain();

		// one substitution allowed
		load_setting(3, 1, pat);
		send_text_byte("a", 1'b1);
		send_text_byte("x", 1'b0);
		send_text_byte("c", 1'b0);
		drain();

		// extreme byte values in pattern and text
		pat = '0;
		pat[15:0] = 16'hFF00;
		load_setting(2, 0, pat);
		send_text_byte(8'hFF, 1'b1);
		send_text_byte(8'h00, 1'b0);
		send_text_byte(8'hFF, 1'b0);
		drain();

		// error limit at the top with a single byte pattern
		pat = (PAT_BYTES*8)'({8{32'($urandom)}});
		load_setting(1, LEVELS - 1, pat);
		send_text_byte(8'($urandom_range(0, 255)), 1'b1);
		send_text_byte(8'($urandom_range(0, 255)), 1'b0);
		drain();

		p = 0;
		while (bytes_in < TARGET_BYTES) begin
			run_random_phase(p);
			p++;
		end

		drain();
		repeat (4) @(negedge clk);
		if (tracker.error_count == 0 && tracker.outstanding() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
